>>> hdl/reorder_buffer_commit_defines.svh
`ifndef REORDER_BUFFER_COMMIT_DEFINES_SVH
`define REORDER_BUFFER_COMMIT_DEFINES_SVH

// same-cycle implication
`define RBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rbc_pkg.sv
package rbc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] OP_FLUSH = 3'd0;
  localparam logic [2:0] OP_WRITEBACK = 3'd1;
  localparam logic [2:0] OP_RETIRE = 3'd2;
  localparam logic [2:0] OP_APPEND = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [3:0] K_RESULT = 4'd0;
  localparam logic [3:0] K_JUMP = 4'd1;
  localparam logic [3:0] K_STORE = 4'd2;
  localparam logic [3:0] K_BEQ = 4'd3;
  localparam logic [3:0] K_BNE = 4'd4;
  localparam logic [3:0] K_BLT = 4'd5;
  localparam logic [3:0] K_BGE = 4'd6;
  localparam logic [3:0] K_BLTU = 4'd7;
  localparam logic [3:0] K_BGEU = 4'd8;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_REG = 3'd1;
  localparam logic [2:0] EV_JUMP = 3'd2;
  localparam logic [2:0] EV_BRANCH = 3'd3;
  localparam logic [2:0] EV_STORE = 3'd4;
  localparam logic [2:0] EV_QUERY = 3'd5;
  localparam logic [2:0] EV_ERROR = 3'd6;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        rdy1;
    logic [4:0]  id1;
    logic [31:0] data1;
    logic        rdy2;
    logic [4:0]  id2;
    logic [31:0] data2;
    logic [31:0] pc;
    logic [31:0] target;
    logic        pred;
  } entry_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [4:0]  commit_tag;
    logic [4:0]  dest_id;
    logic [31:0] out_value;
    logic        query_ready;
    logic        redirect;
    logic [31:0] target_pc;
    logic        taken;
    logic        flush_all;
    logic [31:0] branch_pc;
    logic        full_res;
    logic [4:0]  next_tag;
  } result_t;

  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(ENTRIES - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic logic branch_taken(logic [3:0] k, logic [31:0] a, logic [31:0] b);
    logic [31:0] sa;
    logic [31:0] sb;
    sa = a ^ 32'h8000_0000;
    sb = b ^ 32'h8000_0000;
    case (k)
      K_BEQ:   return a == b;
      K_BNE:   return a != b;
      K_BLT:   return sa < sb;
      K_BGE:   return sa >= sb;
      K_BLTU:  return a < b;
      default: return a >= b;
    endcase
  endfunction

endpackage

>>> hdl/rbc_entry_ram.sv
module rbc_entry_ram (
  input  logic              clk,
  input  logic              we,
  input  rbc_pkg::idx_t     waddr,
  input  rbc_pkg::entry_t   wdata,
  input  logic              re,
  input  rbc_pkg::idx_t     raddr,
  output rbc_pkg::entry_t   rdata
);

  rbc_pkg::entry_t mem [rbc_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/reorder_buffer_commit.sv
// Flush, append and unused ops: the result is registered in the cycle after the item is accepted.
// Retire and query: one entry RAM read, then commit logic.
// Writeback: a read-modify-write sweep over the entry RAM.
// One item in flight; the next is taken once the result has been delivered.
// Sync reset clears head, tail and control; entry RAM contents are not reset.
`include "reorder_buffer_commit_defines.svh"

module reorder_buffer_commit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // kind[3:0], first_ready[4], first_id[9:5], first_value[41:10], second_ready[42],
  // second_id[47:43], second_value[79:48], instr_pc[111:80], branch_target[143:112],
  // predicted_taken[144], zero pad
  input  logic [151:0] s_tdata,
  // op[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // commit_tag[4:0], dest_id[9:5], out_value[41:10], query_ready[42], redirect[43],
  // target_pc[75:44], taken[76], flush_all[77], branch_pc[109:78], full_res[110],
  // next_tag[115:111], zero pad
  output logic [119:0] m_tdata,
  // event_res[2:0]
  output logic [2:0]   m_tuser
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_RETIRE = 4'b0100,
    S_QUERY  = 4'b1000
  } state_t;

  state_t state, state_next;
  rbc_pkg::idx_t head, head_next, tail, tail_next;
  logic [rbc_pkg::CNT_W-1:0] cnt, cnt_next;
  logic rd_pend;
  rbc_pkg::idx_t rd_addr;
  logic [4:0] wb_id, qid;
  logic [31:0] wb_value;
  rbc_pkg::result_t res, res_next;
  logic res_fire;

  logic we, re;
  rbc_pkg::idx_t waddr, raddr;
  rbc_pkg::entry_t wdata, rdata, upd;

  logic in_fire;
  logic [2:0] op;
  logic [3:0] kind;
  logic [4:0] fid;
  rbc_pkg::idx_t live, q_off;
  logic tk;

  assign op = s_tuser;
  assign kind = s_tdata[3:0];
  assign fid = s_tdata[9:5];
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign in_fire = s_tvalid && s_tready;

  rbc_entry_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    upd = rdata;
    if (!rdata.rdy1 && rdata.id1 == wb_id) begin
      upd.data1 = wb_value;
      upd.rdy1 = 1'b1;
    end
    if (!rdata.rdy2 && rdata.id2 == wb_id) begin
      upd.data2 = rdata.data2 + wb_value;
      upd.rdy2 = 1'b1;
    end
  end

  assign live = (tail >= head) ? rbc_pkg::idx_t'(tail - head)
                               : rbc_pkg::idx_t'(rbc_pkg::ENTRIES + tail - head);
  assign q_off = (rbc_pkg::idx_t'(qid) >= head) ? rbc_pkg::idx_t'(rbc_pkg::idx_t'(qid) - head)
                 : rbc_pkg::idx_t'(rbc_pkg::ENTRIES + rbc_pkg::idx_t'(qid) - head);
  assign tk = rbc_pkg::branch_taken(rdata.kind, rdata.data1, rdata.data2);

  always_comb begin
    state_next = state;
    head_next = head;
    tail_next = tail;
    cnt_next = cnt;
    res_next = '0;
    res_fire = 1'b0;
    we = 1'b0;
    waddr = rd_addr;
    wdata = upd;
    re = 1'b0;
    raddr = head;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op)
            rbc_pkg::OP_FLUSH: begin
              head_next = '0;
              tail_next = '0;
              res_fire = 1'b1;
            end
            rbc_pkg::OP_WRITEBACK: begin
              cnt_next = '0;
              state_next = S_SWEEP;
            end
            rbc_pkg::OP_RETIRE: begin
              re = 1'b1;
              state_next = S_RETIRE;
            end
            rbc_pkg::OP_APPEND: begin
              res_fire = 1'b1;
              if (rbc_pkg::idx_inc(tail) == head || kind > rbc_pkg::K_BGEU) begin
                res_next.event_res = rbc_pkg::EV_ERROR;
              end else begin
                we = 1'b1;
                waddr = tail;
                wdata = '{kind: kind, rdy1: s_tdata[4], id1: fid, data1: s_tdata[41:10],
                          rdy2: s_tdata[42], id2: s_tdata[47:43], data2: s_tdata[79:48],
                          pc: s_tdata[111:80], target: s_tdata[143:112], pred: s_tdata[144]};
                tail_next = rbc_pkg::idx_inc(tail);
              end
            end
            rbc_pkg::OP_QUERY: begin
              re = 1'b1;
              raddr = rbc_pkg::idx_t'(fid);
              state_next = S_QUERY;
            end
            default: res_fire = 1'b1;
          endcase
        end
      end
      S_SWEEP: begin
        if (cnt < 6'(rbc_pkg::ENTRIES)) begin
          re = 1'b1;
          raddr = rbc_pkg::idx_t'(cnt);
          cnt_next = cnt + 1'b1;
        end
        if (rd_pend) begin
          we = 1'b1;
          if (rd_addr == rbc_pkg::idx_t'(rbc_pkg::ENTRIES - 1)) begin
            res_fire = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_RETIRE: begin
        res_fire = 1'b1;
        state_next = S_IDLE;
        if (head != tail) begin
          res_next.commit_tag = 5'(head);
          if (rdata.kind == rbc_pkg::K_RESULT || rdata.kind == rbc_pkg::K_JUMP) begin
            if (rdata.rdy1 && (rdata.kind == rbc_pkg::K_RESULT || rdata.rdy2)) begin
              res_next.dest_id = rdata.id1;
              res_next.out_value = rdata.data1;
              if (rdata.kind == rbc_pkg::K_JUMP) begin
                res_next.event_res = rbc_pkg::EV_JUMP;
                res_next.redirect = 1'b1;
                res_next.target_pc = rdata.data2;
              end else begin
                res_next.event_res = rbc_pkg::EV_REG;
              end
              head_next = rbc_pkg::idx_inc(head);
            end
          end else if (rdata.kind == rbc_pkg::K_STORE) begin
            res_next.event_res = rbc_pkg::EV_STORE;
            head_next = rbc_pkg::idx_inc(head);
          end else if (rdata.kind <= rbc_pkg::K_BGEU) begin
            if (rdata.rdy1 && rdata.rdy2) begin
              res_next.event_res = rbc_pkg::EV_BRANCH;
              res_next.taken = tk;
              res_next.branch_pc = rdata.pc;
              if (tk != rdata.pred) begin
                res_next.redirect = 1'b1;
                res_next.target_pc = tk ? rdata.target : rdata.pc + 32'd4;
                res_next.flush_all = 1'b1;
                head_next = '0;
                tail_next = '0;
              end else begin
                head_next = rbc_pkg::idx_inc(head);
              end
            end
          end else begin
            res_next.commit_tag = '0;
            res_next.event_res = rbc_pkg::EV_ERROR;
          end
        end
      end
      S_QUERY: begin
        res_fire = 1'b1;
        state_next = S_IDLE;
        if ({1'b0, qid} >= 6'(rbc_pkg::ENTRIES) || q_off >= live
            || rdata.kind >= rbc_pkg::K_STORE) begin
          res_next.event_res = rbc_pkg::EV_ERROR;
        end else begin
          res_next.event_res = rbc_pkg::EV_QUERY;
          res_next.commit_tag = qid;
          res_next.out_value = rdata.data1;
          res_next.query_ready = rdata.rdy1;
        end
      end
      default: state_next = S_IDLE;
    endcase
    res_next.full_res = (rbc_pkg::idx_inc(tail_next) == head_next)
                     || (rbc_pkg::idx_inc(rbc_pkg::idx_inc(tail_next)) == head_next);
    res_next.next_tag = 5'(tail_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      tail <= '0;
      cnt <= '0;
      rd_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      tail <= tail_next;
      cnt <= cnt_next;
      rd_pend <= (state == S_SWEEP) && re;
      if (res_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= raddr;
    if (res_fire) begin
      res <= res_next;
    end
    if (in_fire) begin
      wb_id <= fid;
      wb_value <= s_tdata[41:10];
      qid <= fid;
    end
  end

  assign m_tuser = res.event_res;
  assign m_tdata = {4'b0, res.next_tag, res.full_res, res.branch_pc, res.flush_all,
                    res.taken, res.target_pc, res.redirect, res.query_ready,
                    res.out_value, res.dest_id, res.commit_tag};

  `RBC_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_tready, "item accepted while busy")
  `RBC_ASSERT_NOW(a_no_result_while_busy, state != S_IDLE, !m_tvalid, "result during work")
  `RBC_ASSERT_NOW(a_flush_empties, m_tvalid && res.flush_all, head == '0 && tail == '0,
                  "mispredict left entries")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  kind;
    logic        fr;
    logic [4:0]  fid;
    logic [31:0] fv;
    logic        sr;
    logic [4:0]  sid;
    logic [31:0] sv;
    logic [31:0] pc;
    logic [31:0] tgt;
    logic        pred;
  } rob_item_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [151:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic [2:0]   m_tuser;

  reorder_buffer_commit u_top (.*);

  rob_item_t          pending_items[$];
  rbc_pkg::result_t   commit_expected[$];
  rob_item_t          cur_item;
  int                 send_idle;
  int                 recv_idle;
  int                 hold_seq;
  int                 hold_seen;
  int                 hold_left;
  int                 errors = 0;
  int                 quiet_cycles;
  int                 ev_count[8];

  // shadow ROB state
  logic [4:0]      rob_head = '0;
  logic [4:0]      rob_tail = '0;
  rbc_pkg::entry_t rob_mem[rbc_pkg::ENTRIES] = '{default: '0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [4:0] wrap_add(logic [4:0] i, int n);
    return 5'((int'(i) + n) % rbc_pkg::ENTRIES);
  endfunction

  function automatic logic resolve_branch(logic [3:0] k, logic [31:0] a, logic [31:0] b);
    case (k)
      rbc_pkg::K_BEQ:  return a == b;
      rbc_pkg::K_BNE:  return a != b;
      rbc_pkg::K_BLT:  return $signed(a) < $signed(b);
      rbc_pkg::K_BGE:  return $signed(a) >= $signed(b);
      rbc_pkg::K_BLTU: return a < b;
      default:         return a >= b;
    endcase
  endfunction

  function automatic rbc_pkg::result_t rob_predict(rob_item_t it);
    rbc_pkg::result_t r;
    rbc_pkg::entry_t  e;
    logic             t;
    int               live;
    int               q_off;
    r = '0;
    r.event_res = rbc_pkg::EV_NONE;
    case (it.op)
      rbc_pkg::OP_FLUSH: begin
        rob_head = '0;
        rob_tail = '0;
      end
      rbc_pkg::OP_WRITEBACK: begin
        for (int i = 0; i < rbc_pkg::ENTRIES; i++) begin
          if (!rob_mem[i].rdy1 && rob_mem[i].id1 == it.fid) begin
            rob_mem[i].data1 = it.fv;
            rob_mem[i].rdy1 = 1'b1;
          end
          if (!rob_mem[i].rdy2 && rob_mem[i].id2 == it.fid) begin
            rob_mem[i].data2 = rob_mem[i].data2 + it.fv;
            rob_mem[i].rdy2 = 1'b1;
          end
        end
      end
      rbc_pkg::OP_RETIRE: begin
        e = rob_mem[rob_head];
        if (rob_head != rob_tail) begin
          r.commit_tag = rob_head;
          if (e.kind == rbc_pkg::K_RESULT || e.kind == rbc_pkg::K_JUMP) begin
            if (e.rdy1 && (e.kind == rbc_pkg::K_RESULT || e.rdy2)) begin
              r.dest_id = e.id1;
              r.out_value = e.data1;
              if (e.kind == rbc_pkg::K_JUMP) begin
                r.redirect = 1'b1;
                r.target_pc = e.data2;
              end
              r.event_res = (e.kind == rbc_pkg::K_RESULT) ? rbc_pkg::EV_REG
                                                          : rbc_pkg::EV_JUMP;
              rob_head = wrap_add(rob_head, 1);
            end
          end else if (e.kind == rbc_pkg::K_STORE) begin
            r.event_res = rbc_pkg::EV_STORE;
            rob_head = wrap_add(rob_head, 1);
          end else if (e.rdy1 && e.rdy2) begin
            t = resolve_branch(e.kind, e.data1, e.data2);
            r.event_res = rbc_pkg::EV_BRANCH;
            r.taken = t;
            r.branch_pc = e.pc;
            if (t != e.pred) begin
              r.redirect = 1'b1;
              r.target_pc = t ? e.target : e.pc + 32'd4;
              r.flush_all = 1'b1;
              rob_head = '0;
              rob_tail = '0;
            end else begin
              rob_head = wrap_add(rob_head, 1);
            end
          end
        end
      end
      rbc_pkg::OP_APPEND: begin
        if (wrap_add(rob_tail, 1) == rob_head || it.kind > rbc_pkg::K_BGEU) begin
          r.event_res = rbc_pkg::EV_ERROR;
        end else begin
          rob_mem[rob_tail] = '{kind: it.kind, rdy1: it.fr, id1: it.fid, data1: it.fv,
                                rdy2: it.sr, id2: it.sid, data2: it.sv, pc: it.pc,
                                target: it.tgt, pred: it.pred};
          rob_tail = wrap_add(rob_tail, 1);
        end
      end
      rbc_pkg::OP_QUERY: begin
        live = (int'(rob_tail) + rbc_pkg::ENTRIES - int'(rob_head)) % rbc_pkg::ENTRIES;
        q_off = (int'(it.fid) + rbc_pkg::ENTRIES - int'(rob_head)) % rbc_pkg::ENTRIES;
        if (q_off >= live || rob_mem[it.fid].kind >= rbc_pkg::K_STORE) begin
          r.event_res = rbc_pkg::EV_ERROR;
        end else begin
          r.event_res = rbc_pkg::EV_QUERY;
          r.commit_tag = it.fid;
          r.out_value = rob_mem[it.fid].data1;
          r.query_ready = rob_mem[it.fid].rdy1;
        end
      end
      default: ;
    endcase
    r.full_res = (wrap_add(rob_tail, 1) == rob_head) || (wrap_add(rob_tail, 2) == rob_head);
    r.next_tag = rob_tail;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic rob_item_t make_item(logic [2:0] op, logic [3:0] kind);
    rob_item_t it;
    it.op = op;
    it.kind = kind;
    it.fr = 1'($urandom_range(0, 1));
    it.sr = 1'($urandom_range(0, 1));
    it.fid = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
    it.sid = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
    it.fv = pick_value();
    it.sv = pick_value();
    it.pc = $urandom;
    it.tgt = $urandom;
    it.pred = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic rob_item_t random_item();
    int w;
    logic [3:0] k;
    w = $urandom_range(0, 99);
    k = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if (w < 36) return make_item(rbc_pkg::OP_APPEND, k);
    if (w < 62) return make_item(rbc_pkg::OP_WRITEBACK, k);
    if (w < 87) return make_item(rbc_pkg::OP_RETIRE, k);
    if (w < 96) return make_item(rbc_pkg::OP_QUERY, k);
    if (w < 98) return make_item(rbc_pkg::OP_FLUSH, k);
    return make_item(3'($urandom_range(5, 7)), k);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_tvalid && s_tready) commit_expected.push_back(rob_predict(cur_item));
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          rob_item_t it;
          it = pending_items.pop_front();
          cur_item <= it;
          s_tvalid <= 1'b1;
          s_tuser <= it.op;
          s_tdata <= {7'b0, it.pred, it.tgt, it.pc, it.sv, it.sid, it.sr, it.fv, it.fid,
                      it.fr, it.kind};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (commit_expected.size() == 0) begin
        $error("unexpected result item, event %0d", m_tuser);
        errors++;
      end else begin
        rbc_pkg::result_t x;
        x = commit_expected.pop_front();
        ev_count[m_tuser]++;
        check_field("event_res", 32'(x.event_res), 32'(m_tuser));
        check_field("commit_tag", 32'(x.commit_tag), 32'(m_tdata[4:0]));
        check_field("dest_id", 32'(x.dest_id), 32'(m_tdata[9:5]));
        check_field("out_value", x.out_value, m_tdata[41:10]);
        check_field("query_ready", 32'(x.query_ready), 32'(m_tdata[42]));
        check_field("redirect", 32'(x.redirect), 32'(m_tdata[43]));
        check_field("target_pc", x.target_pc, m_tdata[75:44]);
        check_field("taken", 32'(x.taken), 32'(m_tdata[76]));
        check_field("flush_all", 32'(x.flush_all), 32'(m_tdata[77]));
        check_field("branch_pc", x.branch_pc, m_tdata[109:78]);
        check_field("full_res", 32'(x.full_res), 32'(m_tdata[110]));
        check_field("next_tag", 32'(x.next_tag), 32'(m_tdata[115:111]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == 3000) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || commit_expected.size() > 0)
      @(negedge clk);
  endtask

  task automatic run_random(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) pending_items.push_back(random_item());
    drain();
  endtask

  initial begin
    rob_item_t it;
    hold_seq = 0;
    send_idle = 0;
    recv_idle = 0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty-buffer cases, every kind, bad kind, unused ops, extremes
    pending_items.push_back(make_item(rbc_pkg::OP_RETIRE, rbc_pkg::K_RESULT));
    pending_items.push_back(make_item(rbc_pkg::OP_QUERY, rbc_pkg::K_RESULT));
    for (int k = 0; k <= 9; k++) begin
      it = make_item(rbc_pkg::OP_APPEND, 4'(k));
      it.fr = 1'b1;
      it.sr = (k != 4);
      it.sid = 5'd31;
      it.fv = (k % 2) ? 32'hFFFF_FFFF : 32'h0;
      it.sv = (k % 3) ? 32'h8000_0000 : 32'h0;
      pending_items.push_back(it);
    end
    for (int q = 0; q < 3; q++) begin
      it = make_item(rbc_pkg::OP_QUERY, rbc_pkg::K_RESULT);
      it.fid = (q == 2) ? 5'd31 : 5'(q * 2);
      pending_items.push_back(it);
    end
    it = make_item(rbc_pkg::OP_WRITEBACK, rbc_pkg::K_RESULT);
    it.fid = 5'd31;
    it.fv = 32'hFFFF_FFFF;
    pending_items.push_back(it);
    repeat (9) pending_items.push_back(make_item(rbc_pkg::OP_RETIRE, rbc_pkg::K_RESULT));
    for (int u = 5; u <= 7; u++) pending_items.push_back(make_item(3'(u), rbc_pkg::K_RESULT));
    pending_items.push_back(make_item(rbc_pkg::OP_FLUSH, rbc_pkg::K_RESULT));
    drain();

    run_random(380, 0, 0);
    run_random(350, 87, 0);
    run_random(350, 0, 87);

    // backpressure: long receiver hold while the buffer is filled past full
    send_idle = 0;
    recv_idle = 0;
    pending_items.push_back(make_item(rbc_pkg::OP_FLUSH, rbc_pkg::K_RESULT));
    for (int i = 0; i < 34; i++)
      pending_items.push_back(make_item(rbc_pkg::OP_APPEND, rbc_pkg::K_STORE));
    @(negedge clk);
    hold_seq = hold_seq + 1;
    drain();
    repeat (40) pending_items.push_back(make_item(rbc_pkg::OP_RETIRE, rbc_pkg::K_RESULT));
    drain();

    run_random(400, 29, 29);

    repeat (60) @(posedge clk);
    $display("tb_top: covered reg %0d, jump %0d, branch %0d, store %0d commits",
             ev_count[rbc_pkg::EV_REG], ev_count[rbc_pkg::EV_JUMP],
             ev_count[rbc_pkg::EV_BRANCH], ev_count[rbc_pkg::EV_STORE]);
    $display("tb_top: %0d query replies, %0d errors, %0d quiet results",
             ev_count[rbc_pkg::EV_QUERY], ev_count[rbc_pkg::EV_ERROR],
             ev_count[rbc_pkg::EV_NONE]);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> reorder_buffer_commit.f
+incdir+hdl
hdl/rbc_pkg.sv
hdl/rbc_entry_ram.sv
hdl/reorder_buffer_commit.sv
sim/tb_top.sv
